// File: rtl/fdl_pkg.sv
// fdl_pkg: shared constants for the fractional delay line
// register map, register widths and parameter defaults; no dependencies

package fdl_pkg;

   // parameter defaults
   localparam int DEPTH_DEFAULT       = 4096;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT   = 8;

   // register widths
   localparam int LEN_BITS   = 13;
   localparam int DELAY_BITS = 20;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = DELAY_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELAY_Q8    = 1'b1;

   // register reset values
   localparam logic [LEN_BITS-1:0]   LEN_RESET   = 13'd4096;
   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 20'd0;

endpackage

// File: rtl/fdl_sample_ram.sv
// fdl_sample_ram: sample store, two registered read ports and one write port
// read returns the old entry when read and write hit the same address; no dependencies

module fdl_sample_ram #(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0]      rd_b_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_a_data,
   output logic signed [SAMPLE_BITS-1:0] rd_b_data,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data
);

   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_data <= mem[rd_a_addr];
         rd_b_data <= mem[rd_b_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

// File: rtl/fdl_interp.sv
// fdl_interp: linear interpolation pipeline a + ((b - a) * f) >> frac, floor shift
// difference and product stages, then the sum formed into the output register; no dependencies

module fdl_interp #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_a,
   input  logic signed [SAMPLE_BITS-1:0] in_b,
   input  logic [FRAC_BITS-1:0]          in_frac,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   localparam int SB = SAMPLE_BITS;
   localparam int FB = FRAC_BITS;

   logic                 s3_v_ff, s3_v_in;
   logic signed [SB-1:0] s3_a_ff;
   logic signed [SB:0]   s3_dba_ff;
   logic [FB-1:0]        s3_frac_ff;

   logic                 s4_v_ff, s4_v_in;
   logic signed [SB-1:0] s4_a_ff;
   logic [SB+FB:0]       s4_prod_ff;

   logic                 out_v_ff, out_v_in;
   logic [SB-1:0]        out_sample_ff, out_sample_in;

   logic                 take, mv3, mv4;
   logic signed [SB:0]   dba_in;
   logic signed [FB:0]   frac_s;
   logic signed [SB+FB+1:0] prod_full;
   logic [SB+FB:0]       a_shift, sum;

   assign mv4      = s4_v_ff && (!out_v_ff || out_ready);
   assign mv3      = s3_v_ff && (!s4_v_ff || mv4);
   assign in_ready = !s3_v_ff || mv3;
   assign take     = in_valid && in_ready;

   assign s3_v_in  = take | (s3_v_ff & !mv3);
   assign s4_v_in  = mv3 | (s4_v_ff & !mv4);
   assign out_v_in = mv4 | (out_v_ff & !out_ready);

   always_comb begin
      dba_in    = {in_b[SB-1], in_b} - {in_a[SB-1], in_a};
      frac_s    = {1'b0, s3_frac_ff};
      prod_full = s3_dba_ff * frac_s;
      // a shifted left by FB bits, sign extended to the product width
      a_shift   = {s4_a_ff[SB-1], s4_a_ff, {FB{1'b0}}};
      sum       = a_shift + s4_prod_ff;
      // bit select of the two's complement sum is the floor shift
      out_sample_in = sum[SB+FB-1:FB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s3_v_ff  <= s3_v_in;
         s4_v_ff  <= s4_v_in;
         out_v_ff <= out_v_in;
      end
      if (take) begin
         s3_a_ff    <= in_a;
         s3_dba_ff  <= dba_in;
         s3_frac_ff <= in_frac;
      end
      if (mv3) begin
         s4_a_ff    <= s3_a_ff;
         s4_prod_ff <= prod_full[SB+FB:0];
      end
      if (mv4) begin
         out_sample_ff <= out_sample_in;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_sample = out_sample_ff;

endmodule

// File: rtl/fractional_delay_line.sv
// Fractional delay line with linear interpolation. Every input beat reads the two stored
// samples around the fractional tap (write index minus delay, modulo the line length) and
// writes the new sample in the same memory cycle, so the read always sees the line as it
// was before this sample; one result beat follows each input beat. The pipeline accepts
// one beat per clock when the output is taken, and each result passes through the address,
// memory read, difference, multiply and sum registers in that order. After reset a
// clearing pass zeroes every entry of the store, one entry per cycle, with req_ready low.
// After each configuration write req_ready stays low while the clamped line length and
// delay settle. Depends on fdl_pkg, fdl_sample_ram and fdl_interp.

module fractional_delay_line #(
   parameter int DEPTH       = fdl_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   input  logic                                  csr_write_en,
   input  logic [fdl_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [fdl_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int AW   = $clog2(DEPTH);
   localparam int LENW = AW + 1;
   localparam int FB   = FRAC_BITS;
   localparam int PW   = AW + FRAC_BITS;
   localparam int DW   = fdl_pkg::DELAY_BITS;
   localparam int CW   = (DW > LENW + FB) ? DW : LENW + FB;

   // configuration
   logic [fdl_pkg::LEN_BITS-1:0] len_raw_ff;
   logic [DW-1:0]                delay_raw_ff;
   logic [LENW-1:0]              len_eff_ff, len_eff_in;
   logic [PW-1:0]                d_cl_ff, d_cl_in;
   logic [1:0]                   settle_ff, settle_in;
   logic [LENW-1:0]              len_m1;
   logic [LENW+FB-1:0]           max_delay;

   // clearing pass
   logic                         clr_busy_ff, clr_busy_in;
   logic [AW-1:0]                clr_addr_ff, clr_addr_in;

   // write index and address stage
   logic [AW-1:0]                wr_idx_ff, wr_idx_in;
   logic                         s1_v_ff, s1_v_in;
   logic [PW:0]                  s1_diff_ff;
   logic [AW-1:0]                s1_wi_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;

   // memory read stage
   logic                         s2_v_ff, s2_v_in;
   logic [FB-1:0]                s2_frac_ff;

   logic                         accept, mv1, mv2, itp_ready;
   logic [AW-1:0]                wi_fix;
   logic [LENW-1:0]              wi_inc;
   logic [PW-1:0]                wpos, pos, len_pos;
   logic [PW:0]                  diff_in;
   logic [AW-1:0]                ia, ib;
   logic [LENW-1:0]              ib_inc;
   logic [FB-1:0]                frac;

   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic signed [SAMPLE_BITS-1:0] ram_wr_data;
   logic signed [SAMPLE_BITS-1:0] rd_a_data, rd_b_data;

   // clamp the line length, then the delay against it
   always_comb begin
      if (32'(len_raw_ff) < 32'd2) begin
         len_eff_in = LENW'(2);
      end else if (32'(len_raw_ff) > 32'(DEPTH)) begin
         len_eff_in = LENW'(DEPTH);
      end else begin
         len_eff_in = LENW'(len_raw_ff);
      end
      len_m1    = len_eff_ff - LENW'(1);
      max_delay = {len_m1, {FB{1'b0}}};
      if (CW'(delay_raw_ff) > CW'(max_delay)) begin
         d_cl_in = PW'(max_delay);
      end else begin
         d_cl_in = PW'(delay_raw_ff);
      end
      settle_in = csr_write_en ? 2'd2 : ((settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0);
   end

   always_comb begin
      clr_addr_in = clr_addr_ff + AW'(1);
      clr_busy_in = clr_busy_ff && (clr_addr_ff != AW'(DEPTH - 1));
   end

   // pipeline handshake
   assign mv2       = s2_v_ff && itp_ready;
   assign mv1       = s1_v_ff && (!s2_v_ff || mv2);
   assign req_ready = !clr_busy_ff && (settle_ff == 2'd0) && (!s1_v_ff || mv1);
   assign accept    = req_valid && req_ready;
   assign s1_v_in   = accept | (s1_v_ff & !mv1);
   assign s2_v_in   = mv1 | (s2_v_ff & !mv2);

   // accept stage: tap position relative to the write index
   always_comb begin
      // a write index left past a shortened line restarts at zero
      wi_fix    = ({1'b0, wr_idx_ff} >= len_eff_ff) ? '0 : wr_idx_ff;
      wpos      = {wi_fix, {FB{1'b0}}};
      diff_in   = {1'b0, wpos} - {1'b0, d_cl_ff};
      wi_inc    = {1'b0, wi_fix} + LENW'(1);
      wr_idx_in = (wi_inc == len_eff_ff) ? '0 : wi_inc[AW-1:0];
   end

   // address stage: wrap the tap and form both read addresses
   always_comb begin
      len_pos = PW'({len_eff_ff, {FB{1'b0}}});
      pos     = s1_diff_ff[PW] ? s1_diff_ff[PW-1:0] + len_pos : s1_diff_ff[PW-1:0];
      ia      = pos[PW-1:FB];
      frac    = pos[FB-1:0];
      ib_inc  = {1'b0, ia} + LENW'(1);
      ib      = (ib_inc == len_eff_ff) ? '0 : ib_inc[AW-1:0];
   end

   // the clearing pass owns the write port until done
   always_comb begin
      ram_wr_en   = clr_busy_ff || mv1;
      ram_wr_addr = clr_busy_ff ? clr_addr_ff : s1_wi_ff;
      ram_wr_data = clr_busy_ff ? '0 : s1_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_raw_ff   <= fdl_pkg::LEN_RESET;
         delay_raw_ff <= fdl_pkg::DELAY_RESET;
         settle_ff    <= 2'd2;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         wr_idx_ff    <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               fdl_pkg::REG_LINE_LENGTH: len_raw_ff   <= csr_wdata[fdl_pkg::LEN_BITS-1:0];
               fdl_pkg::REG_DELAY_Q8:    delay_raw_ff <= csr_wdata[DW-1:0];
               default: ;
            endcase
         end
         settle_ff <= settle_in;
         if (clr_busy_ff) begin
            clr_busy_ff <= clr_busy_in;
            clr_addr_ff <= clr_addr_in;
         end
         if (accept) begin
            wr_idx_ff <= wr_idx_in;
         end
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
      len_eff_ff <= len_eff_in;
      d_cl_ff    <= d_cl_in;
      if (accept) begin
         s1_diff_ff   <= diff_in;
         s1_wi_ff     <= wi_fix;
         s1_sample_ff <= req_sample_in;
      end
      if (mv1) begin
         s2_frac_ff <= frac;
      end
   end

   fdl_sample_ram #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ram (
      .clock     (clock),
      .rd_en     (mv1),
      .rd_a_addr (ia),
      .rd_b_addr (ib),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data)
   );

   fdl_interp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_interp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_v_ff),
      .in_ready   (itp_ready),
      .in_a       (rd_a_data),
      .in_b       (rd_b_data),
      .in_frac    (s2_frac_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_sample (rsp_sample_out)
   );

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !clr_busy_ff)
      else $error("input beat accepted during clearing pass");

   a_settle_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !req_ready)
      else $error("input accepted before configuration settled");

   a_read_in_line: assert property (@(posedge clock) disable iff (reset)
      mv1 |-> (({1'b0, ia} < len_eff_ff) && ({1'b0, ib} < len_eff_ff)))
      else $error("read address outside the line");

   a_pair_adjacent: assert property (@(posedge clock) disable iff (reset)
      mv1 |-> ((ib == '0) || ({1'b0, ib} == {1'b0, ia} + LENW'(1))))
      else $error("second tap not next to first");

   a_write_in_line: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> ({1'b0, s1_wi_ff} < len_eff_ff))
      else $error("write index outside the line");
`endif

endmodule
